[hw/rtl/size_class_bitmap_block_allocator_macros.svh]
// assertion macros shared by the allocator rtl
`ifndef SIZE_CLASS_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SBBA_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("sbba: assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SBBA_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("sbba: assertion failed");

`endif

[hw/rtl/sbba_pkg.sv]
// types and constants of the size-class bitmap block allocator
`default_nettype none

package sbba_pkg;

    // fixed field widths
    localparam int CLASS_W   = 3;
    localparam int MASK_W    = 6;
    localparam int SIZE_W    = 24;
    localparam int OFF_W     = 21;
    localparam int IDXO_W    = 10;
    localparam int USED_W    = 11;
    localparam int STAT_W    = 3;
    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int CLASS_SLOTS = 2 ** CLASS_W;

    localparam logic [MASK_W-1:0] MASK_RESET = 6'h3F;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTUSED = 3'd5;

    typedef struct packed {
        logic               cmd;
        logic [SIZE_W-1:0]  req_size;
        logic [CLASS_W-1:0] free_class;
        logic [OFF_W-1:0]   free_offset;
    } sbba_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [CLASS_W-1:0] class_index;
        logic [IDXO_W-1:0]  block_index;
        logic [OFF_W-1:0]   block_offset;
        logic [USED_W-1:0]  class_used;
    } sbba_result_t;

    // log2 of the block size of a class: 64 << 2c
    function automatic logic [4:0] class_shift(input logic [CLASS_W-1:0] c);
        return 5'd6 + {1'b0, c, 1'b0};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/size_class_bitmap_block_allocator.sv]
// top level of the size-class bitmap block allocator
//
//  channel   ports                    handshake
//  config    cfg_we, cfg_wdata        written on any edge with cfg_we high
//  command   start, busy, item        taken on an edge with start high, busy low
//  result    done, result             one beat per command, held one cycle only
//
//  allocate: the map word scan (one 64-bit word per cycle) starts at the first
//    word of the class and ends at the word holding the first free block, or
//    after the last word of the class with status full
//  free: one map read, then one write-back if the block was in use; zero size, no
//    fit and bad class or index report in the cycle after accept and busy stays low
//  after reset a clearing pass zeroes the map, NUM_CLASSES * ceil(blocks/64)
//    words (96 at default settings) with busy high; config is taken meanwhile
//  the receiver cannot stall; done pulses once per command
`default_nettype none
`include "size_class_bitmap_block_allocator_macros.svh"

module size_class_bitmap_block_allocator #(
    parameter int NUM_CLASSES          = 6,
    parameter int LARGEST_CLASS_BLOCKS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sbba_pkg::MASK_W-1:0]   cfg_wdata,
    input  wire logic                          start,
    input  wire sbba_pkg::sbba_item_t          item,
    output logic                               busy,
    output logic                               done,
    output sbba_pkg::sbba_result_t             result
);

    import sbba_pkg::*;

    localparam int MAP_WORDS = (LARGEST_CLASS_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int DEPTH     = NUM_CLASSES * MAP_WORDS;
    localparam int AW        = $clog2(DEPTH);
    localparam int IDX_W     = $clog2(LARGEST_CLASS_BLOCKS);
    localparam int NB_W      = $clog2(LARGEST_CLASS_BLOCKS + 1);
    localparam int RW        = NB_W + 1;
    localparam int WC_W      = $clog2(MAP_WORDS + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_CHK
    } state_t;

    state_t               state_reg, state_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic [NB_W-1:0]      cnt_reg [NUM_CLASSES];
    logic [NB_W-1:0]      cnt_next [NUM_CLASSES];
    logic [CLASS_W-1:0]   cls_reg, cls_next;
    logic [IDX_W-1:0]     fidx_reg, fidx_next;
    logic [WC_W-1:0]      rd_w_reg, rd_w_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [WC_W-1:0]      chk_w_reg, chk_w_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic                 done_reg, done_next;
    sbba_result_t         result_reg, result_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic [CLASS_SLOTS-1:0] pres;
    logic                 fit;
    logic [CLASS_W-1:0]   sel_cls;
    logic [OFF_W-1:0]     f_idx_full;
    logic [NB_W-1:0]      f_nblk;
    logic                 f_class_ok;
    logic                 f_in_range;
    logic [IDX_W-1:0]     f_idx;
    logic [WC_W-1:0]      f_word;
    logic [NB_W-1:0]      f_cnt;
    logic [NB_W-1:0]      cur_cnt;
    logic [NB_W-1:0]      cur_nblk;
    logic [WC_W-1:0]      cur_words;
    logic [RW-1:0]        word_base;
    logic [RW-1:0]        word_rem;
    logic [WORD_W-1:0]    bit_mask;
    logic [WORD_W-1:0]    avail;
    logic                 found;
    logic [BIT_W-1:0]     found_pos;
    logic [IDX_W-1:0]     found_idx;
    logic                 go_long;

    // map word address of a class and word
    function automatic logic [AW-1:0] map_addr(input logic [CLASS_W-1:0] c,
                                               input logic [WC_W-1:0] w);
        return AW'(c) * AW'(MAP_WORDS) + AW'(w);
    endfunction

    // byte offset of a block, masked to the field width
    function automatic logic [OFF_W-1:0] off_of(input logic [IDX_W-1:0] idx,
                                                input logic [CLASS_W-1:0] c);
        logic [IDX_W+OFF_W-1:0] wide;
        wide = (IDX_W + OFF_W)'(idx) << class_shift(c);
        return wide[OFF_W-1:0];
    endfunction

    function automatic logic [IDXO_W-1:0] idx_out(input logic [IDX_W-1:0] idx);
        logic [IDX_W+IDXO_W-1:0] wide;
        wide = (IDX_W + IDXO_W)'(idx);
        return wide[IDXO_W-1:0];
    endfunction

    function automatic logic [USED_W-1:0] used_out(input logic [NB_W-1:0] cnt);
        logic [NB_W+USED_W-1:0] wide;
        wide = (NB_W + USED_W)'(cnt);
        return wide[USED_W-1:0];
    endfunction

    // map memory
    sbba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pres = {(CLASS_SLOTS - MASK_W)'(0), mask_reg};

    // smallest present class that holds the request
    always_comb
    begin
        fit     = 1'b0;
        sel_cls = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (pres[c] && ({1'b0, item.req_size} <= ((SIZE_W + 1)'(1)
                    << class_shift(CLASS_W'(c)))))
            begin
                fit     = 1'b1;
                sel_cls = CLASS_W'(c);
            end
        end
    end

    // free command decode
    assign f_idx_full = item.free_offset >> class_shift(item.free_class);
    assign f_nblk     = NB_W'(LARGEST_CLASS_BLOCKS) >> item.free_class;
    assign f_class_ok = ((CLASS_W + 1)'(item.free_class) < (CLASS_W + 1)'(NUM_CLASSES))
                        && pres[item.free_class];
    assign f_in_range = f_idx_full < OFF_W'(f_nblk);
    assign f_idx      = f_idx_full[IDX_W-1:0];
    assign f_word     = WC_W'(f_idx >> BIT_W);

    // used counts of the freed class and of the working class
    always_comb
    begin
        f_cnt   = '0;
        cur_cnt = '0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if (CLASS_W'(k) == item.free_class)
            begin
                f_cnt = cnt_reg[k];
            end
            if (CLASS_W'(k) == cls_reg)
            begin
                cur_cnt = cnt_reg[k];
            end
        end
    end

    // geometry of the working class
    assign cur_nblk  = NB_W'(LARGEST_CLASS_BLOCKS) >> cls_reg;
    assign cur_words = WC_W'((RW'(cur_nblk) + RW'(WORD_W - 1)) >> BIT_W);

    // free bits of the checked word, limited to blocks of the class
    assign word_base = RW'(chk_w_reg) << BIT_W;
    assign word_rem  = RW'(cur_nblk) - word_base;
    assign bit_mask  = (word_rem >= RW'(WORD_W)) ? '1
                     : ((WORD_W'(1) << word_rem[BIT_W-1:0]) - WORD_W'(1));
    assign avail     = ~ram_rdata & bit_mask;
    assign found     = |avail;

    // lowest free bit
    always_comb
    begin
        found_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                found_pos = BIT_W'(b);
            end
        end
    end

    assign found_idx = IDX_W'(((IDX_W + BIT_W)'(chk_w_reg) << BIT_W)
                              | (IDX_W + BIT_W)'(found_pos));

    // next-state logic
    always_comb
    begin
        state_next    = state_reg;
        mask_next     = cfg_we ? cfg_wdata : mask_reg;
        cnt_next      = cnt_reg;
        cls_next      = cls_reg;
        fidx_next     = fidx_reg;
        rd_w_next     = rd_w_reg;
        chk_vld_next  = 1'b0;
        chk_w_next    = chk_w_reg;
        clr_addr_next = clr_addr_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = clr_addr_reg;
        ram_wdata     = '0;
        ram_raddr     = map_addr(cls_reg, rd_w_reg);
        go_long       = 1'b0;

        unique case (state_reg)
            // zero the map one word per cycle
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            // take a command, report early errors, start the map read
            S_IDLE:
            begin
                if (start)
                begin
                    result_next.block_index  = '0;
                    result_next.block_offset = '0;
                    result_next.class_used   = '0;
                    if (item.cmd == CMD_FREE)
                    begin
                        ram_raddr               = map_addr(item.free_class, f_word);
                        result_next.status      = ST_RANGE;
                        result_next.class_index = item.free_class;
                        if (!f_class_ok)
                        begin
                            done_next = 1'b1;
                        end
                        else if (!f_in_range)
                        begin
                            done_next              = 1'b1;
                            result_next.class_used = used_out(f_cnt);
                        end
                        else
                        begin
                            go_long    = 1'b1;
                            cls_next   = item.free_class;
                            fidx_next  = f_idx;
                            state_next = S_FREE_CHK;
                        end
                    end
                    else
                    begin
                        ram_raddr               = map_addr(sel_cls, '0);
                        result_next.class_index = '0;
                        if (item.req_size == '0)
                        begin
                            done_next          = 1'b1;
                            result_next.status = ST_ZERO;
                        end
                        else if (!fit)
                        begin
                            done_next          = 1'b1;
                            result_next.status = ST_NOFIT;
                        end
                        else
                        begin
                            go_long      = 1'b1;
                            cls_next     = sel_cls;
                            rd_w_next    = WC_W'(1);
                            chk_vld_next = 1'b1;
                            chk_w_next   = '0;
                            state_next   = S_SCAN;
                        end
                    end
                end
            end

            // one word read and one word checked per cycle
            S_SCAN:
            begin
                if (rd_w_reg < cur_words)
                begin
                    chk_vld_next = 1'b1;
                    chk_w_next   = rd_w_reg;
                    rd_w_next    = rd_w_reg + WC_W'(1);
                end
                if (chk_vld_reg)
                begin
                    if (found)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = map_addr(cls_reg, chk_w_reg);
                        ram_wdata = ram_rdata | (WORD_W'(1) << found_pos);
                        for (int k = 0; k < NUM_CLASSES; k++)
                        begin
                            if (CLASS_W'(k) == cls_reg)
                            begin
                                cnt_next[k] = cur_cnt + NB_W'(1);
                            end
                        end
                        done_next                = 1'b1;
                        result_next.status       = ST_OK;
                        result_next.class_index  = cls_reg;
                        result_next.block_index  = idx_out(found_idx);
                        result_next.block_offset = off_of(found_idx, cls_reg);
                        result_next.class_used   = used_out(cur_cnt + NB_W'(1));
                        state_next               = S_IDLE;
                    end
                    else if ((WC_W + 1)'(chk_w_reg) + (WC_W + 1)'(1)
                             >= (WC_W + 1)'(cur_words))
                    begin
                        done_next                = 1'b1;
                        result_next.status       = ST_FULL;
                        result_next.class_index  = cls_reg;
                        result_next.block_index  = '0;
                        result_next.block_offset = '0;
                        result_next.class_used   = used_out(cur_cnt);
                        state_next               = S_IDLE;
                    end
                end
            end

            // check the freed bit and, if it was set, write it back cleared
            S_FREE_CHK:
            begin
                done_next                = 1'b1;
                result_next.class_index  = cls_reg;
                result_next.block_index  = idx_out(fidx_reg);
                result_next.block_offset = off_of(fidx_reg, cls_reg);
                state_next               = S_IDLE;
                if (!ram_rdata[fidx_reg[BIT_W-1:0]])
                begin
                    result_next.status     = ST_NOTUSED;
                    result_next.class_used = used_out(cur_cnt);
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = map_addr(cls_reg, WC_W'(fidx_reg >> BIT_W));
                    ram_wdata = ram_rdata & ~(WORD_W'(1) << fidx_reg[BIT_W-1:0]);
                    result_next.status = ST_OK;
                    for (int k = 0; k < NUM_CLASSES; k++)
                    begin
                        if (CLASS_W'(k) == cls_reg)
                        begin
                            cnt_next[k] = (cur_cnt == '0) ? '0 : cur_cnt - NB_W'(1);
                        end
                    end
                    result_next.class_used =
                        used_out((cur_cnt == '0) ? '0 : cur_cnt - NB_W'(1));
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            mask_reg     <= MASK_RESET;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                cnt_reg[k] <= '0;
            end
            cls_reg      <= '0;
            fidx_reg     <= '0;
            rd_w_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            chk_w_reg    <= '0;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mask_reg     <= mask_next;
            cnt_reg      <= cnt_next;
            cls_reg      <= cls_next;
            fidx_reg     <= fidx_next;
            rd_w_reg     <= rd_w_next;
            chk_vld_reg  <= chk_vld_next;
            chk_w_reg    <= chk_w_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // a command that needs the map keeps the block busy the next cycle
    `SBBA_ASSERT_NEXT(a_long_busy, go_long, busy && !done)
    // every map write-back ends the command with a result beat
    `SBBA_ASSERT_NEXT(a_wb_done, ram_we && state_reg != S_CLEAR, done && !busy)
    // the scan never checks a word past the end of its class
    `SBBA_ASSERT_IMPL(a_scan_bound, state_reg == S_SCAN && chk_vld_reg, chk_w_reg < cur_words)
    // write-back goes to the word read the cycle before
    `SBBA_ASSERT_IMPL(a_wb_addr, ram_we && state_reg != S_CLEAR, ram_waddr == $past(ram_raddr))

endmodule

`default_nettype wire

[hw/rtl/sbba_ram.sv]
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none

module sbba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[verif/tb.sv]
// self-checking testbench for the size-class bitmap block allocator
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbba_pkg::*;

    localparam int NCLS       = 6;
    localparam int TOP_BLOCKS = 1024;
    localparam int MAX_PRINTS = 50;

    // model of the used maps, the present mask and the results still owed by the block
    class alloc_scoreboard;
        logic [TOP_BLOCKS-1:0] used_map [NCLS];
        int unsigned           used_cnt [NCLS];
        logic [MASK_W-1:0]     present;
        sbba_result_t          pending_results [$];
        int                    errors;
        int                    checked;
        int                    status_seen [8];

        function new();
            present = MASK_RESET;
            errors  = 0;
            checked = 0;
            for (int c = 0; c < NCLS; c++)
            begin
                used_map[c] = '0;
                used_cnt[c] = 0;
            end
            foreach (status_seen[s])
                status_seen[s] = 0;
        endfunction

        // log2 of the block size of class c
        function int unsigned blk_shift(int c);
            return 6 + 2 * c;
        endfunction

        function int unsigned blk_count(int c);
            return TOP_BLOCKS >> c;
        endfunction

        function void set_mask(logic [MASK_W-1:0] m);
            present = m;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // work out the result of one accepted command beat
        function void note_item(sbba_item_t it);
            sbba_result_t r;
            int           c;
            int unsigned  idx;
            r = '0;
            if (it.cmd == CMD_ALLOC)
            begin
                if (it.req_size == '0)
                    r.status = ST_ZERO;
                else
                begin
                    // smallest present class large enough
                    c = 0;
                    while (c < NCLS &&
                           !(present[c] && (64'd1 << blk_shift(c)) >= 64'(it.req_size)))
                        c++;
                    if (c == NCLS)
                        r.status = ST_NOFIT;
                    else
                    begin
                        idx = 0;
                        while (idx < blk_count(c) && used_map[c][idx])
                            idx++;
                        r.class_index = CLASS_W'(c);
                        if (idx == blk_count(c))
                        begin
                            r.status     = ST_FULL;
                            r.class_used = USED_W'(used_cnt[c]);
                        end
                        else
                        begin
                            used_map[c][idx] = 1'b1;
                            used_cnt[c]++;
                            r.status       = ST_OK;
                            r.block_index  = IDXO_W'(idx);
                            r.block_offset = OFF_W'(idx << blk_shift(c));
                            r.class_used   = USED_W'(used_cnt[c]);
                        end
                    end
                end
            end
            else
            begin
                c = int'(it.free_class);
                r.class_index = it.free_class;
                if (c >= NCLS || !present[c])
                    r.status = ST_RANGE;
                else
                begin
                    idx = int'(it.free_offset) >> blk_shift(c);
                    if (idx >= blk_count(c))
                    begin
                        r.status     = ST_RANGE;
                        r.class_used = USED_W'(used_cnt[c]);
                    end
                    else
                    begin
                        // double free leaves the map alone
                        if (used_map[c][idx])
                        begin
                            used_map[c][idx] = 1'b0;
                            if (used_cnt[c] > 0)
                                used_cnt[c]--;
                            r.status = ST_OK;
                        end
                        else
                            r.status = ST_NOTUSED;
                        r.block_index  = IDXO_W'(idx);
                        r.block_offset = OFF_W'(idx << blk_shift(c));
                        r.class_used   = USED_W'(used_cnt[c]);
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        // compare one result beat with the oldest prediction
        task check_result(sbba_result_t got);
            sbba_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result beat with nothing pending: %h", got));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.class_index !== want.class_index)
                report($sformatf("class_index %0d, want %0d",
                                 got.class_index, want.class_index));
            if (got.block_index !== want.block_index)
                report($sformatf("block_index %0d, want %0d",
                                 got.block_index, want.block_index));
            if (got.block_offset !== want.block_offset)
                report($sformatf("block_offset %0d, want %0d",
                                 got.block_offset, want.block_offset));
            if (got.class_used !== want.class_used)
                report($sformatf("class_used %0d, want %0d",
                                 got.class_used, want.class_used));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [MASK_W-1:0] cfg_wdata;
    logic              start;
    sbba_item_t        cmd_item;
    logic              busy;
    logic              done;
    sbba_result_t      res;

    alloc_scoreboard sb;
    int              sent;
    int              masks_written;
    int              burst_left;

    size_class_bitmap_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .item      (cmd_item),
        .busy      (busy),
        .done      (done),
        .result    (res)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watch both channels and the config port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(res);
            if (cfg_we)
                sb.set_mask(cfg_wdata);
            if (start && !busy)
                sb.note_item(cmd_item);
        end
    end

    // idle cycles before the next beat, with runs of back-to-back beats
    function int unsigned draw_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            burst_left = $urandom_range(10, 40);
        return $urandom_range(0, 6);
    endfunction

    function sbba_item_t alloc_cmd(int unsigned size);
        sbba_item_t it;
        it.cmd         = CMD_ALLOC;
        it.req_size    = SIZE_W'(size);
        it.free_class  = CLASS_W'($urandom);
        it.free_offset = OFF_W'($urandom);
        return it;
    endfunction

    function sbba_item_t free_cmd(int unsigned c, int unsigned off);
        sbba_item_t it;
        it.cmd         = CMD_FREE;
        it.req_size    = SIZE_W'($urandom);
        it.free_class  = CLASS_W'(c);
        it.free_offset = OFF_W'(off);
        return it;
    endfunction

    // request size: mostly aimed at one class, some zero and some too large
    function int unsigned pick_size(int focus);
        int unsigned roll;
        int unsigned k;
        int unsigned hi;
        int unsigned lo;
        roll = $urandom_range(0, 99);
        if (focus < 0 && roll < 3)
            return 0;
        if (focus < 0 && roll < 8)
            return $urandom & 32'hFF_FFFF;
        if (focus < 0 && roll < 12)
            return $urandom_range(65537, 32'hFF_FFFF);
        k  = (focus < 0) ? $urandom_range(0, NCLS - 1) : focus;
        hi = 1 << (6 + 2 * k);
        lo = (k == 0) ? 1 : (hi >> 2) + 1;
        if ($urandom_range(0, 3) == 0)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    // alloc_pct percent allocations; the rest mostly frees of blocks likely in use, some double frees and noise
    function sbba_item_t mixed_item(int alloc_pct, int focus);
        sbba_item_t  it;
        int unsigned c;
        int unsigned idx;
        int unsigned sh;
        if ($urandom_range(0, 99) < alloc_pct)
            return alloc_cmd(pick_size(focus));
        it = free_cmd($urandom, $urandom);
        if (focus < 0 && $urandom_range(0, 19) == 0)
            return it;
        c   = (focus < 0) ? $urandom_range(0, NCLS - 1) : focus;
        sh  = 6 + 2 * c;
        idx = $urandom_range(0, sb.used_cnt[c] + 1);
        return free_cmd(c, (idx << sh) | ($urandom & ((1 << sh) - 1)));
    endfunction

    // hand one command beat to the block and wait until it is taken
    task send(sbba_item_t it);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cmd_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    // hold off until every predicted result has come back
    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task write_mask(logic [MASK_W-1:0] m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        masks_written++;
    endtask

    task run_phase(int n, int alloc_pct, int focus);
        for (int i = 0; i < n; i++)
            send(mixed_item(alloc_pct, focus));
    endtask

    // run timeout
    initial
    begin
        #(5_000_000);
        $display("[size_class_bitmap_block_allocator] ERROR");
        $finish;
    end

    initial
    begin
        sb            = new();
        sent          = 0;
        masks_written = 0;
        burst_left    = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        start         = 1'b0;
        cmd_item      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_mask(6'h3F);

        // directed: zero size, class boundaries, no fit
        send(alloc_cmd(0));
        send(alloc_cmd(1));
        send(alloc_cmd(64));
        send(alloc_cmd(65));
        send(alloc_cmd(256));
        send(alloc_cmd(257));
        send(alloc_cmd(1024));
        send(alloc_cmd(1025));
        send(alloc_cmd(4096));
        send(alloc_cmd(4097));
        send(alloc_cmd(16384));
        send(alloc_cmd(16385));
        send(alloc_cmd(65536));
        send(alloc_cmd(65537));
        send(alloc_cmd(32'hFF_FFFF));
        // directed: frees, double free, unaligned offset, bad class and index
        send(free_cmd(0, 0));
        send(free_cmd(0, 0));
        send(free_cmd(0, 64 + 5));
        send(free_cmd(6, 0));
        send(free_cmd(7, 32'h1F_FFFF));
        send(free_cmd(0, 65536));
        send(free_cmd(5, 32'h1F_FFFF));
        send(free_cmd(5, 65536));

        // sender pauses until all results are back
        drain();
        run_phase(200, 70, -1);

        // some classes absent
        write_mask(6'h2A);
        run_phase(150, 60, -1);

        // no class present
        write_mask(6'h00);
        run_phase(30, 50, -1);

        // fill the smallest class toward the top of its map, then run mostly frees in it
        write_mask(6'h3F);
        run_phase(1100, 96, 0);
        run_phase(40, 20, 0);

        write_mask(MASK_W'($urandom_range(1, 62)));
        run_phase(150, 55, -1);

        drain();
        repeat (20) @(posedge clk);
        $display("run: %0d commands, %0d results checked, %0d mask writes",
                 sent, sb.checked, masks_written);
        $display("statuses: ok %0d, zero %0d, no fit %0d, full %0d, range %0d, not used %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_ZERO], sb.status_seen[ST_NOFIT],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_RANGE],
                 sb.status_seen[ST_NOTUSED]);
        if (sb.errors == 0)
            $display("[size_class_bitmap_block_allocator] OK");
        else
            $display("[size_class_bitmap_block_allocator] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
